// ===== hdl/sfp_pkg.sv =====
// Shared types and constants for the serial frame parser with XOR check.
`default_nettype none
package sfp_pkg;

  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd254;

  // Class of one frame byte, decided by the front end
  typedef enum logic [2:0] {
    OP_LEN,
    OP_CMD1,
    OP_CMD2,
    OP_DATA,
    OP_FCS
  } op_t;

  // Result kind codes
  typedef enum logic [KIND_W-1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_GOOD    = 2'd2,
    KIND_BAD     = 2'd3
  } kind_t;

  // One queue entry between front and back
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/sfp_if.sv =====
// Valid/ready channel interfaces for received bytes and parser results.
`default_nettype none
interface sfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [7:0] frame_length;
  logic [7:0] command_high;
  logic [7:0] command_low;

  modport source (output valid, output kind, output payload_byte, output frame_length,
                  output command_high, output command_low, input ready);
  modport sink   (input valid, input kind, input payload_byte, input frame_length,
                  input command_high, input command_low, output ready);
endinterface
`default_nettype wire

// ===== hdl/sfp_front.sv =====
// Front end: hunts for the start byte, tracks frame phase and classifies each byte.
`default_nettype none
module sfp_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_wr_en,
  input  wire logic [sfp_pkg::BYTE_W-1:0] cfg_wr_data,
  sfp_in_if.sink                        rx,
  output logic                          push_valid,
  input  wire logic                     push_ready,
  output sfp_pkg::entry_t               push_entry
);
  import sfp_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_LEN,
    PH_CMD1,
    PH_CMD2,
    PH_DATA,
    PH_FCS
  } phase_t;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] length, length_next;
  logic [BYTE_W-1:0] count, count_next;
  logic              accept;

  assign rx.ready = push_ready;
  assign accept   = rx.valid && push_ready;

  // Classify the incoming byte and advance the phase
  always_comb begin
    phase_next      = phase;
    length_next     = length;
    count_next      = count;
    push_valid      = 1'b0;
    push_entry.op   = OP_LEN;
    push_entry.data = rx.rx_byte;
    if (accept) begin
      unique case (phase)
        PH_WAIT: begin
          if (rx.rx_byte == start_byte) phase_next = PH_LEN;
        end
        PH_LEN: begin
          push_valid  = 1'b1;
          length_next = rx.rx_byte;
          count_next  = '0;
          phase_next  = PH_CMD1;
        end
        PH_CMD1: begin
          push_valid    = 1'b1;
          push_entry.op = OP_CMD1;
          phase_next    = PH_CMD2;
        end
        PH_CMD2: begin
          push_valid    = 1'b1;
          push_entry.op = OP_CMD2;
          phase_next    = (length != '0) ? PH_DATA : PH_FCS;
        end
        PH_DATA: begin
          push_valid    = 1'b1;
          push_entry.op = OP_DATA;
          count_next    = count + 1'b1;
          if (count_next == length) phase_next = PH_FCS;
        end
        PH_FCS: begin
          push_valid    = 1'b1;
          push_entry.op = OP_FCS;
          phase_next    = PH_WAIT;
        end
        default: begin
          phase_next = PH_WAIT;
        end
      endcase
    end
  end

  // Hold phase, counters and the start byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT;
      length     <= '0;
      count      <= '0;
      start_byte <= START_BYTE_RESET;
    end else begin
      phase  <= phase_next;
      length <= length_next;
      count  <= count_next;
      if (cfg_wr_en) start_byte <= cfg_wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sfp_queue.sv =====
// Short FIFO of classified bytes between the front and back ends.
`default_nettype none
module sfp_queue #(
  parameter int DEPTH = sfp_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire sfp_pkg::entry_t push_entry,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output sfp_pkg::entry_t      pop_entry
);
  import sfp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  entry_t          slots [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue occupancy above depth");

  a_push_only_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on a lone push");

  a_pop_only_shrinks: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not shrink on a lone pop");

endmodule
`default_nettype wire

// ===== hdl/sfp_back.sv =====
// Back end: keeps header fields and running XOR, and registers each result.
`default_nettype none
module sfp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire sfp_pkg::entry_t pop_entry,
  sfp_out_if.source            res
);
  import sfp_pkg::*;

  logic [BYTE_W-1:0] frame_len, cmd_hi, cmd_lo, running_check;
  logic              out_valid;
  kind_t             out_kind;
  logic [BYTE_W-1:0] out_payload, out_len, out_hi, out_lo;
  logic              has_result;
  logic              do_pop;

  assign has_result = (pop_entry.op == OP_CMD2) || (pop_entry.op == OP_DATA) ||
                      (pop_entry.op == OP_FCS);
  assign pop_ready  = !has_result || !out_valid || res.ready;
  assign do_pop     = pop_valid && pop_ready;

  assign res.valid        = out_valid;
  assign res.kind         = out_kind;
  assign res.payload_byte = out_payload;
  assign res.frame_length = out_len;
  assign res.command_high = out_hi;
  assign res.command_low  = out_lo;

  // Update frame fields and the running check
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len     <= '0;
      cmd_hi        <= '0;
      cmd_lo        <= '0;
      running_check <= '0;
    end else if (do_pop) begin
      unique case (pop_entry.op)
        OP_LEN: begin
          frame_len     <= pop_entry.data;
          running_check <= pop_entry.data;
        end
        OP_CMD1: begin
          cmd_hi        <= pop_entry.data;
          running_check <= running_check ^ pop_entry.data;
        end
        OP_CMD2: begin
          cmd_lo        <= pop_entry.data;
          running_check <= running_check ^ pop_entry.data;
        end
        OP_DATA: running_check <= running_check ^ pop_entry.data;
        OP_FCS:  ;
        default: ;
      endcase
    end
  end

  // Output valid: set on a result, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_pop && has_result) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (do_pop && has_result) begin
      out_len     <= frame_len;
      out_hi      <= cmd_hi;
      out_lo      <= cmd_lo;
      out_payload <= '0;
      case (pop_entry.op)
        OP_CMD2: begin
          out_kind <= KIND_HEADER;
          out_lo   <= pop_entry.data;
        end
        OP_DATA: begin
          out_kind    <= KIND_PAYLOAD;
          out_payload <= pop_entry.data;
        end
        default: begin
          out_kind <= (pop_entry.data == running_check) ? KIND_GOOD : KIND_BAD;
        end
      endcase
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> (out_valid && $stable(out_kind)))
    else $error("stalled result changed");

  a_no_pop_over_result: assert property (@(posedge clk) disable iff (rst)
    (do_pop && has_result && out_valid) |-> res.ready)
    else $error("result overwritten before transfer");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != KIND_PAYLOAD) |-> (out_payload == '0))
    else $error("payload byte set on a non-payload result");

endmodule
`default_nettype wire

// ===== hdl/serial_frame_parser_xor_fcs_core.sv =====
// Top level of the serial frame parser with XOR frame check.
//
//  channel   dir  handshake          payload
//  rx        in   rx.valid/rx.ready   rx_byte
//  res       out  res.valid/res.ready kind, payload_byte, frame_length,
//                                      command_high, command_low
//  cfg       in   cfg_wr_en          cfg_wr_data -> start_byte
//
// One byte is accepted per cycle while rx.ready is high; results are registered.
// The front end tracks frame phase; a small FIFO feeds the back end, which
// keeps the header fields and running XOR and owns the output register.
// rx.ready drops only when the FIFO is full (the result side stalled).
// Reset (rst, synchronous) clears all control state and sets start_byte to 254.
`default_nettype none
module serial_frame_parser_xor_fcs_core #(
  parameter int QUEUE_DEPTH = sfp_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [sfp_pkg::BYTE_W-1:0] cfg_wr_data,
  sfp_in_if.sink                          rx,
  sfp_out_if.source                       res
);
  import sfp_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_entry, pop_entry;

  // Classify incoming bytes
  sfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_entry  (push_entry)
  );

  // Decouple front and back
  sfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Build and deliver results
  sfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .res       (res)
  );

endmodule
`default_nettype wire
